FILE: hw/rtl/qpcc_pkg.sv
// Shared types, codes and coefficient tables for the quadric pair collapse cost block.
package qpcc_pkg;

	localparam int COEF_COUNT = 10;
	localparam int CAND_COUNT = 3;
	localparam int COEF_W     = 33;
	localparam int ACC_W      = 104;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	localparam logic [1:0] CHOICE_P0  = 2'd0;
	localparam logic [1:0] CHOICE_MID = 2'd1;
	localparam logic [1:0] CHOICE_P1  = 2'd2;

	typedef struct packed {
		logic               action;
		logic [3:0]         coef_index;
		logic signed [31:0] coef_first;
		logic signed [31:0] coef_second;
		logic signed [31:0] p0_x;
		logic signed [31:0] p0_y;
		logic signed [31:0] p0_z;
		logic signed [31:0] p0_w;
		logic signed [31:0] p1_x;
		logic signed [31:0] p1_y;
		logic signed [31:0] p1_z;
		logic signed [31:0] p1_w;
	} in_t;

	typedef struct packed {
		logic signed [31:0] best_x;
		logic signed [31:0] best_y;
		logic signed [31:0] best_z;
		logic signed [31:0] best_w;
		logic [63:0]        min_error;
		logic [1:0]         choice;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	typedef struct packed {
		logic       load_en;
		logic       capture;
		logic       issue;
		logic [1:0] cand;
		logic [3:0] coef;
		logic       first;
		logic       last;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic       vld;
		logic       dbl;
		logic       first;
		logic       last;
		logic [1:0] cand;
	} tag_t;

	function automatic logic [1:0] row_of(input logic [3:0] k);
		logic [1:0] r;
		case (k)
			4'd0, 4'd1, 4'd2, 4'd3: r = 2'd0;
			4'd4, 4'd5, 4'd6:       r = 2'd1;
			4'd7, 4'd8:             r = 2'd2;
			default:                r = 2'd3;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] col_of(input logic [3:0] k);
		logic [1:0] c;
		case (k)
			4'd0:             c = 2'd0;
			4'd1, 4'd4:       c = 2'd1;
			4'd2, 4'd5, 4'd7: c = 2'd2;
			default:          c = 2'd3;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/qpcc_ctrl.sv
// Controller: handshakes, term sequencing over candidates and output register valid.
module qpcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              done,
	output qpcc_pkg::cmd_t    cmd
);

	qpcc_pkg::state_t state_q, state_d;
	logic [1:0] cand_q;
	logic [3:0] coef_q;
	logic       out_valid_q;
	logic       accept;
	logic       coef_end;
	logic       slot_free;

	assign in_ready  = (state_q == qpcc_pkg::ST_IDLE);
	assign accept    = in_valid & in_ready;
	assign coef_end  = (coef_q == 4'(qpcc_pkg::COEF_COUNT - 1));
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load_en  = accept && (action == qpcc_pkg::ACT_LOAD);
		cmd.capture  = accept && (action == qpcc_pkg::ACT_EVAL);
		cmd.issue    = (state_q == qpcc_pkg::ST_RUN);
		cmd.cand     = cand_q;
		cmd.coef     = coef_q;
		cmd.first    = (coef_q == 4'd0);
		cmd.last     = coef_end;
		cmd.out_load = slot_free && ((state_q == qpcc_pkg::ST_WAIT && done) ||
			state_q == qpcc_pkg::ST_HOLD);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			qpcc_pkg::ST_IDLE: begin
				if (cmd.capture)
					state_d = qpcc_pkg::ST_RUN;
			end
			qpcc_pkg::ST_RUN: begin
				if (coef_end && cand_q == 2'(qpcc_pkg::CAND_COUNT - 1))
					state_d = qpcc_pkg::ST_WAIT;
			end
			qpcc_pkg::ST_WAIT: begin
				if (done)
					state_d = slot_free ? qpcc_pkg::ST_IDLE : qpcc_pkg::ST_HOLD;
			end
			qpcc_pkg::ST_HOLD: begin
				if (slot_free)
					state_d = qpcc_pkg::ST_IDLE;
			end
			default: state_d = qpcc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qpcc_pkg::ST_IDLE;
			cand_q      <= '0;
			coef_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				cand_q <= '0;
				coef_q <= '0;
			end else if (cmd.issue) begin
				if (coef_end) begin
					coef_q <= '0;
					cand_q <= cand_q + 2'd1;
				end else begin
					coef_q <= coef_q + 4'd1;
				end
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hw/rtl/qpcc_dp.sv
// Datapath: coefficient store, candidates, pipelined term multiply, accumulate and compare.
module qpcc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  qpcc_pkg::in_t     item,
	input  qpcc_pkg::cmd_t    cmd,
	output logic              done,
	output qpcc_pkg::out_t    result
);

	logic signed [qpcc_pkg::COEF_W-1:0] quad_q [qpcc_pkg::COEF_COUNT];
	logic signed [31:0] cand_q [qpcc_pkg::CAND_COUNT][4];

	logic signed [31:0] p0 [4];
	logic signed [31:0] p1 [4];
	logic signed [32:0] mid_sum [4];

	logic signed [31:0]                 a_op, b_op;
	logic signed [63:0]                 prod_s1;
	logic signed [qpcc_pkg::COEF_W-1:0] c_s1;
	qpcc_pkg::tag_t                     tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [65:0]                 lo_s2;
	logic signed [64:0]                 hi_s2;
	logic signed [qpcc_pkg::ACC_W-1:0]  term, term_s3;
	logic signed [qpcc_pkg::ACC_W-1:0]  acc_q;
	logic [63:0]                        score;
	logic [63:0]                        best_err_q;
	logic [1:0]                         best_choice_q;
	logic                               done_q;
	logic                               fin;
	logic                               better;
	qpcc_pkg::tag_t                     tag_in;

	assign p0[0] = item.p0_x;
	assign p0[1] = item.p0_y;
	assign p0[2] = item.p0_z;
	assign p0[3] = item.p0_w;
	assign p1[0] = item.p1_x;
	assign p1[1] = item.p1_y;
	assign p1[2] = item.p1_z;
	assign p1[3] = item.p1_w;

	always_comb begin
		for (int i = 0; i < 4; i++)
			mid_sum[i] = 33'(p0[i]) + 33'(p1[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < qpcc_pkg::COEF_COUNT; i++)
				quad_q[i] <= '0;
		end else if (cmd.load_en && item.coef_index < 4'(qpcc_pkg::COEF_COUNT)) begin
			quad_q[item.coef_index] <= 33'(item.coef_first) + 33'(item.coef_second);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int i = 0; i < 4; i++) begin
				cand_q[qpcc_pkg::CHOICE_P0][i]  <= p0[i];
				cand_q[qpcc_pkg::CHOICE_MID][i] <= mid_sum[i][32:1];
				cand_q[qpcc_pkg::CHOICE_P1][i]  <= p1[i];
			end
		end
	end

	assign a_op = cand_q[cmd.cand][qpcc_pkg::row_of(cmd.coef)];
	assign b_op = cand_q[cmd.cand][qpcc_pkg::col_of(cmd.coef)];

	always_comb begin
		tag_in       = '0;
		tag_in.vld   = cmd.issue;
		tag_in.dbl   = (qpcc_pkg::row_of(cmd.coef) != qpcc_pkg::col_of(cmd.coef));
		tag_in.first = cmd.first;
		tag_in.last  = cmd.last;
		tag_in.cand  = cmd.cand;
	end

	// term = 2^dbl * c * (hi:lo of a*b); 64x33 product split in two partials
	always_comb begin
		term = (qpcc_pkg::ACC_W'(hi_s2) <<< 32) + qpcc_pkg::ACC_W'(lo_s2);
		if (tag_s2.dbl)
			term = term <<< 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a_op * b_op;
		c_s1    <= quad_q[cmd.coef];
		lo_s2   <= $signed({34'd0, prod_s1[31:0]}) * 66'(c_s1);
		hi_s2   <= 65'($signed(prod_s1[63:32])) * 65'(c_s1);
		term_s3 <= term;
		if (tag_s3.vld)
			acc_q <= (tag_s3.first ? '0 : acc_q) + term_s3;
	end

	always_comb begin
		if (acc_q[qpcc_pkg::ACC_W-1])
			score = '0;
		else if (|acc_q[qpcc_pkg::ACC_W-2:80])
			score = '1;
		else
			score = acc_q[79:16];
	end

	assign fin    = tag_s4.vld && tag_s4.last;
	assign better = (tag_s4.cand == qpcc_pkg::CHOICE_P0) || (score < best_err_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q        <= 1'b0;
			best_err_q    <= '0;
			best_choice_q <= qpcc_pkg::CHOICE_P0;
		end else begin
			done_q <= fin && (tag_s4.cand == qpcc_pkg::CHOICE_P1);
			if (fin && better) begin
				best_err_q    <= score;
				best_choice_q <= tag_s4.cand;
			end
		end
	end

	assign done = done_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result.best_x    <= cand_q[best_choice_q][0];
			result.best_y    <= cand_q[best_choice_q][1];
			result.best_z    <= cand_q[best_choice_q][2];
			result.best_w    <= cand_q[best_choice_q][3];
			result.min_error <= best_err_q;
			result.choice    <= best_choice_q;
		end
	end

endmodule

FILE: hw/rtl/quadric_pair_collapse_cost.sv
// Top level of the quadric pair collapse cost block.
//
// Input channel (in_valid/in_ready/in_data): a load transaction (action 0)
// writes coef_first + coef_second into summed coefficient coef_index; indexes
// above nine are dropped. Loads give no result and keep the input ready.
// An evaluate transaction (action 1) scores endpoint 0, the midpoint and
// endpoint 1 against the summed quadric and returns one transaction on
// out_valid/out_ready/out_data with the winning position, its error and choice.
// One shared multiply pipeline handles one of the 30 quadratic-form terms per
// cycle; the input is not ready from the acceptance of an evaluate until its
// result is loaded into the output register.
// The result sits in an output register, so a new transaction is accepted
// while out_valid waits; a further evaluate stalls only if its own result is
// ready while the earlier one is still not taken.
// Reset clears all ten coefficients to zero and drops any pending result.
module quadric_pair_collapse_cost (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  qpcc_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output qpcc_pkg::out_t  out_data
);

	qpcc_pkg::cmd_t cmd;
	logic           done;

	qpcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (in_data.action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.done      (done),
		.cmd       (cmd)
	);

	qpcc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_data),
		.cmd    (cmd),
		.done   (done),
		.result (out_data)
	);

endmodule

FILE: verif/tb_top.sv
// Testbench for the quadric pair collapse cost block: random loads and evaluates, checked against a fixed-point scorer.
`timescale 1ns / 100ps

module tb_top;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	qpcc_pkg::in_t  in_data;
	logic out_valid;
	logic out_ready;
	qpcc_pkg::out_t out_data;

	quadric_pair_collapse_cost dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	qpcc_pkg::in_t  pending_items[$];
	qpcc_pkg::out_t expected_costs[$];
	logic signed [32:0] quad_sum[qpcc_pkg::COEF_COUNT];
	int   errors;
	int   cycle_count;
	bit   hold_input;
	bit   in_taken;
	int   send_gap;
	int   recv_gap;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 40);
	endfunction

	// exact v^T Q v in Q48.48, floored to Q32.32, clamped and saturated
	function automatic logic [63:0] form_cost(input logic signed [32:0] v[4]);
		logic signed [127:0] acc;
		logic signed [127:0] term;
		logic [1:0] r;
		logic [1:0] c;
		acc = '0;
		for (int k = 0; k < qpcc_pkg::COEF_COUNT; k++) begin
			case (k)
				0, 1, 2, 3: r = 2'd0;
				4, 5, 6:    r = 2'd1;
				7, 8:       r = 2'd2;
				default:    r = 2'd3;
			endcase
			case (k)
				0:       c = 2'd0;
				1, 4:    c = 2'd1;
				2, 5, 7: c = 2'd2;
				default: c = 2'd3;
			endcase
			term = 128'(v[r]) * 128'(v[c]) * 128'(quad_sum[k]);
			if (r != c)
				term = term * 2;
			acc = acc + term;
		end
		if (acc < 0)
			return 64'd0;
		if (acc[127:80] != 0)
			return {64{1'b1}};
		return acc[79:16];
	endfunction

	function automatic void predict(input qpcc_pkg::in_t it);
		logic signed [32:0] cand[3][4];
		logic signed [32:0] s;
		logic [63:0] best_cost;
		logic [63:0] cost;
		int best;
		qpcc_pkg::out_t res;
		if (it.action == qpcc_pkg::ACT_LOAD) begin
			if (it.coef_index < qpcc_pkg::COEF_COUNT)
				quad_sum[it.coef_index] = 33'(it.coef_first) + 33'(it.coef_second);
			return;
		end
		cand[0] = '{33'(it.p0_x), 33'(it.p0_y), 33'(it.p0_z), 33'(it.p0_w)};
		cand[2] = '{33'(it.p1_x), 33'(it.p1_y), 33'(it.p1_z), 33'(it.p1_w)};
		for (int i = 0; i < 4; i++) begin
			s = cand[0][i] + cand[2][i];
			cand[1][i] = 33'($signed(s[32:1]));
		end
		best = 0;
		best_cost = form_cost(cand[0]);
		for (int i = 1; i < 3; i++) begin
			cost = form_cost(cand[i]);
			if (cost < best_cost) begin
				best_cost = cost;
				best = i;
			end
		end
		res.best_x = cand[best][0][31:0];
		res.best_y = cand[best][1][31:0];
		res.best_z = cand[best][2][31:0];
		res.best_w = cand[best][3][31:0];
		res.min_error = best_cost;
		res.choice = (best == 0) ? qpcc_pkg::CHOICE_P0 :
			(best == 1) ? qpcc_pkg::CHOICE_MID : qpcc_pkg::CHOICE_P1;
		expected_costs.push_back(res);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return '0;
			3: return 32'hffffffff;
			4, 5: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
			default: return $urandom;
		endcase
	endfunction

	// small magnitudes keep scores in range so the choice varies
	function automatic logic [31:0] mild_word();
		return 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh3ffff);
	endfunction

	function automatic qpcc_pkg::in_t make_load(input int idx, input bit mild);
		qpcc_pkg::in_t it;
		it = '0;
		it.action = qpcc_pkg::ACT_LOAD;
		it.coef_index = 4'(idx);
		it.coef_first = mild ? mild_word() : rand_word();
		it.coef_second = mild ? mild_word() : rand_word();
		it.p0_x = $urandom; it.p0_y = $urandom; it.p0_z = $urandom; it.p0_w = $urandom;
		it.p1_x = $urandom; it.p1_y = $urandom; it.p1_z = $urandom; it.p1_w = $urandom;
		return it;
	endfunction

	function automatic qpcc_pkg::in_t make_eval(input bit mild);
		qpcc_pkg::in_t it;
		it = make_load($urandom_range(0, 15), 0);
		it.action = qpcc_pkg::ACT_EVAL;
		if (mild) begin
			it.p0_x = mild_word(); it.p0_y = mild_word();
			it.p0_z = mild_word(); it.p0_w = mild_word();
			it.p1_x = mild_word(); it.p1_y = mild_word();
			it.p1_z = mild_word(); it.p1_w = mild_word();
		end else begin
			it.p0_x = rand_word(); it.p0_y = rand_word();
			it.p0_z = rand_word(); it.p0_w = rand_word();
			it.p1_x = rand_word(); it.p1_y = rand_word();
			it.p1_z = rand_word(); it.p1_w = rand_word();
		end
		return it;
	endfunction

	initial begin
		qpcc_pkg::in_t it;
		bit mild;
		// zero quadric: all ties, endpoint zero wins
		pending_items.push_back(make_eval(0));
		// extremes of the coefficient sum
		it = make_load(0, 0);
		it.coef_first = 32'h7fffffff; it.coef_second = 32'h7fffffff;
		pending_items.push_back(it);
		it = make_eval(0);
		it.p0_x = 32'h80000000; it.p1_x = 32'h80000000;
		pending_items.push_back(it);
		it = make_load(0, 0);
		it.coef_first = 32'h80000000; it.coef_second = 32'h80000000;
		pending_items.push_back(it);
		pending_items.push_back(make_eval(0));
		// out-of-range index is dropped
		it = make_load(15, 0);
		pending_items.push_back(it);
		it = make_load(10, 0);
		pending_items.push_back(it);
		for (int k = 0; k < qpcc_pkg::COEF_COUNT; k++)
			pending_items.push_back(make_load(k, 1));
		// odd sums exercise the midpoint floor
		it = make_eval(1);
		it.p0_x = 32'h1; it.p1_x = 32'h0; it.p0_y = 32'hffffffff; it.p1_y = 32'h0;
		pending_items.push_back(it);
		pending_items.push_back(make_eval(0));
		pending_items.push_back(make_eval(1));
		for (int n = 0; n < 1500; n++) begin
			mild = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 2) == 0)
				pending_items.push_back(make_load($urandom_range(0, 15), mild));
			else
				pending_items.push_back(make_eval(mild));
		end
	end

	// transaction taken at the last rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_taken <= 1'b0;
		else
			in_taken <= in_valid && in_ready;
	end

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else if (in_valid && !in_taken) begin
			// hold
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_items.size() > 0 && !hold_input) begin
			in_valid <= 1'b1;
			in_data <= pending_items.pop_front();
			send_gap <= pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// one pause until the pipe drains
	initial begin
		hold_input = 1'b0;
		wait (pending_items.size() == 700);
		hold_input = 1'b1;
		wait (expected_costs.size() == 0 && !in_valid);
		hold_input = 1'b0;
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
		end else if (recv_gap > 0) begin
			out_ready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else begin
			out_ready <= 1'b1;
			recv_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		qpcc_pkg::out_t exp_res;
		if (arst_n) begin
			if (in_valid && in_ready)
				predict(in_data);
			if (out_valid && out_ready) begin
				if (expected_costs.size() == 0) begin
					$display("%0t: unexpected result %h", $time, out_data);
					errors++;
				end else begin
					exp_res = expected_costs.pop_front();
					if (out_data !== exp_res) begin
						$display("%0t: mismatch expected %h actual %h", $time, exp_res, out_data);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		errors = 0;
		cycle_count = 0;
		for (int k = 0; k < qpcc_pkg::COEF_COUNT; k++)
			quad_sum[k] = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n = 1'b1;
		while (pending_items.size() > 0 || in_valid || expected_costs.size() > 0) begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
		repeat (60) @(posedge clk);
		if (errors == 0 && expected_costs.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
